@@ rtl/gamepad_event_to_pad_bits_macros.svh @@
// Assertion macros shared by the checker of the gamepad event block.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef GAMEPAD_EVENT_TO_PAD_BITS_MACROS_SVH
`define GAMEPAD_EVENT_TO_PAD_BITS_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GPB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GPB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/gpb_pkg.sv @@
// Package of the gamepad event block: field widths, codes and shared types.
// It depends on nothing and is used by every RTL module of the block.
package gpb_pkg;

  localparam int MAX_PADS    = 4;
  localparam int MAP_W       = 36;
  localparam int ENTRY_W     = 6;
  localparam int NUM_ENTRIES = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int S_TDATA_W   = 40;
  localparam int M_TDATA_W   = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_PAD_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_PAD0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_PAD1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_PAD2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_PAD3   = 3'd4;

  localparam logic [6:0] EVT_BUTTON = 7'd1;
  localparam logic [6:0] EVT_AXIS   = 7'd2;

  localparam logic [7:0] AXIS_X = 8'd0;
  localparam logic [7:0] AXIS_Y = 8'd1;

  localparam logic signed [15:0] AXIS_LIMIT = 16'sd16383;

  localparam int BIT_UP    = 4;
  localparam int BIT_DOWN  = 5;
  localparam int BIT_LEFT  = 6;
  localparam int BIT_RIGHT = 7;

  typedef enum logic {
    REQ_EVENT = 1'b0,
    REQ_POLL  = 1'b1
  } gpb_req_e;

  typedef struct packed {
    gpb_req_e           req;
    logic [1:0]         pad;
    logic [7:0]         ev_type;
    logic [7:0]         number;
    logic signed [15:0] value;
  } gpb_req_t;

endpackage

@@ rtl/gpb_pad_state.sv @@
// Per-pad button masks and stick positions, plus the turbo phase flip-flop.
// Uses gpb_pkg; driven by the request stage of gamepad_event_to_pad_bits.
module gpb_pad_state import gpb_pkg::*; #(
  parameter int NUM_PADS    = 4,
  parameter int NUM_BUTTONS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  fire_i,
  input  gpb_req_t                              req_i,
  input  logic [MAX_PADS-1:0]                   pad_enable_i,
  output logic [NUM_PADS-1:0][NUM_BUTTONS-1:0]  mask_o,
  output logic [NUM_PADS-1:0][15:0]             axis_x_o,
  output logic [NUM_PADS-1:0][15:0]             axis_y_o,
  output logic                                  turbo_o
);

  logic turbo_q;

  for (genvar p = 0; p < NUM_PADS; p++) begin : g_pad
    logic [NUM_BUTTONS-1:0] mask_q, mask_d;
    logic [15:0]            ax_q, ax_d, ay_q, ay_d;
    logic                   hit;

    assign hit = fire_i && (req_i.req == REQ_EVENT) && (req_i.pad == 2'(p)) &&
                 pad_enable_i[p];

    always_comb begin
      mask_d = mask_q;
      ax_d   = ax_q;
      ay_d   = ay_q;
      if (hit) begin
        if (req_i.ev_type[6:0] == EVT_BUTTON) begin
          for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (req_i.number == 8'(b)) begin
              mask_d[b] = (req_i.value != 16'sd0);
            end
          end
        end else if (req_i.ev_type[6:0] == EVT_AXIS) begin
          if (req_i.number == AXIS_X) begin
            ax_d = req_i.value;
          end else if (req_i.number == AXIS_Y) begin
            ay_d = req_i.value;
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mask_q <= '0;
        ax_q   <= '0;
        ay_q   <= '0;
      end else begin
        mask_q <= mask_d;
        ax_q   <= ax_d;
        ay_q   <= ay_d;
      end
    end

    assign mask_o[p]   = mask_q;
    assign axis_x_o[p] = ax_q;
    assign axis_y_o[p] = ay_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turbo_q <= 1'b0;
    end else if (fire_i && (req_i.req == REQ_POLL)) begin
      turbo_q <= ~turbo_q;
    end
  end

  assign turbo_o = turbo_q;

endmodule

@@ rtl/gpb_poll.sv @@
// Forms the polled pad word from masks, sticks, button maps and turbo phase.
// Uses gpb_pkg; purely combinational, fed by gpb_pad_state and the top level.
module gpb_poll import gpb_pkg::*; #(
  parameter int NUM_PADS    = 4,
  parameter int NUM_BUTTONS = 32
) (
  input  logic [NUM_PADS-1:0][NUM_BUTTONS-1:0] mask_i,
  input  logic [NUM_PADS-1:0][15:0]            axis_x_i,
  input  logic [NUM_PADS-1:0][15:0]            axis_y_i,
  input  logic [MAX_PADS-1:0][MAP_W-1:0]       map_i,
  input  logic [MAX_PADS-1:0]                  pad_enable_i,
  input  logic                                 phase_i,
  output logic [M_TDATA_W-1:0]                 word_o
);

  always_comb begin
    logic [31:0]         mask32;
    logic [ENTRY_W-1:0]  ent;
    logic [7:0]          pbyte;
    logic signed [15:0]  ax, ay;
    word_o = '0;
    for (int p = 0; p < NUM_PADS; p++) begin
      mask32 = 32'(mask_i[p]);
      ax     = $signed(axis_x_i[p]);
      ay     = $signed(axis_y_i[p]);
      pbyte  = '0;
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        ent = map_i[p][ENTRY_W*e +: ENTRY_W];
        if (ent[5] && mask32[ent[4:0]] && ((e < 4) || phase_i)) begin
          pbyte[e % 4] = 1'b1;
        end
      end
      if (ax <= -AXIS_LIMIT) begin
        pbyte[BIT_LEFT] = 1'b1;
      end else if (ax >= AXIS_LIMIT) begin
        pbyte[BIT_RIGHT] = 1'b1;
      end
      if (ay <= -AXIS_LIMIT) begin
        pbyte[BIT_UP] = 1'b1;
      end else if (ay >= AXIS_LIMIT) begin
        pbyte[BIT_DOWN] = 1'b1;
      end
      if (pad_enable_i[p]) begin
        word_o[8*p +: 8] = pbyte;
      end
    end
  end

endmodule

@@ rtl/gamepad_event_to_pad_bits.sv @@
// Top level of the gamepad event collector and pad bit poller.
// Uses gpb_pkg, gpb_pad_state and gpb_poll.
//
//   channel      | direction | carries
//   s_axis       | in        | one joystick event or one poll request
//   m_axis       | out       | one 32-bit pad word per poll
//   cfg          | in        | register writes: pad_enable, map_pad0..map_pad3
//
// Every transaction passes through the request register, and each poll
// word is then held in the output register. One request is accepted
// per cycle; m_axis_tready low stalls only when a poll word waits
// and another poll sits in the request register. Reset clears all pad state,
// turbo phase, config registers and valid flags; no clearing pass follows.
module gamepad_event_to_pad_bits import gpb_pkg::*; #(
  parameter int NUM_PADS    = 4,
  parameter int NUM_BUTTONS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [1:0] pad, [9:2] event_type, [17:10] event_number, [33:18] event_value
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  // [0] req_type
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [31:0] pad_bits
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [MAP_W-1:0]      cfg_data_i
);

  logic                            s1_valid_q;
  gpb_req_t                        s1_req_q;
  logic                            out_valid_q;
  logic [M_TDATA_W-1:0]            out_data_q;
  logic [MAX_PADS-1:0]             pad_enable_q;
  logic [MAX_PADS-1:0][MAP_W-1:0]  map_q;
  logic                            out_free, s1_adv, in_fire;
  gpb_req_t                        in_req;
  logic [NUM_PADS-1:0][NUM_BUTTONS-1:0] mask;
  logic [NUM_PADS-1:0][15:0]       axis_x, axis_y;
  logic                            turbo;
  logic [M_TDATA_W-1:0]            word;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && ((s1_req_q.req == REQ_EVENT) || out_free);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    in_req.req     = gpb_req_e'(s_axis_tuser);
    in_req.pad     = s_axis_tdata[1:0];
    in_req.ev_type = s_axis_tdata[9:2];
    in_req.number  = s_axis_tdata[17:10];
    in_req.value   = $signed(s_axis_tdata[33:18]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_req_q <= in_req;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_enable_q <= '0;
      map_q        <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_PAD_ENABLE: pad_enable_q <= cfg_data_i[MAX_PADS-1:0];
        CFG_MAP_PAD0:   map_q[0]     <= cfg_data_i;
        CFG_MAP_PAD1:   map_q[1]     <= cfg_data_i;
        CFG_MAP_PAD2:   map_q[2]     <= cfg_data_i;
        CFG_MAP_PAD3:   map_q[3]     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gpb_pad_state #(
    .NUM_PADS    (NUM_PADS),
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_state (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (s1_adv),
    .req_i        (s1_req_q),
    .pad_enable_i (pad_enable_q),
    .mask_o       (mask),
    .axis_x_o     (axis_x),
    .axis_y_o     (axis_y),
    .turbo_o      (turbo)
  );

  gpb_poll #(
    .NUM_PADS    (NUM_PADS),
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_poll (
    .mask_i       (mask),
    .axis_x_i     (axis_x),
    .axis_y_i     (axis_y),
    .map_i        (map_q),
    .pad_enable_i (pad_enable_q),
    .phase_i      (~turbo),
    .word_o       (word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && (s1_req_q.req == REQ_POLL)) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && (s1_req_q.req == REQ_POLL)) begin
      out_data_q <= word;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ rtl/gpb_checker.sv @@
// Port-level checker for gamepad_event_to_pad_bits, attached by bind.
// Uses gpb_pkg and the assertion macros of the block's header file.
`include "gamepad_event_to_pad_bits_macros.svh"

module gpb_checker import gpb_pkg::*; #(
  parameter int NUM_PADS = 4
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [M_TDATA_W-1:0]  m_axis_tdata
);

  localparam int USED_BITS = 8 * NUM_PADS;

  logic [M_TDATA_W-1:0] unused_bytes;
  logic                 stalled;
  logic                 out_free;

  assign unused_bytes = (USED_BITS >= M_TDATA_W) ? '0 : (m_axis_tdata >> USED_BITS);
  assign stalled      = m_axis_tvalid && !m_axis_tready;
  assign out_free     = !m_axis_tvalid || m_axis_tready;

  `GPB_ASSERT_NEXT(a_out_hold, stalled, m_axis_tvalid, "result dropped while stalled")
  `GPB_ASSERT_NEXT(a_out_stable, stalled, $stable(m_axis_tdata), "result changed while stalled")
  `GPB_ASSERT_NOW(a_ready_when_free, out_free, s_axis_tready, "input blocked with free output")
  `GPB_ASSERT_NOW(a_absent_pads_zero, m_axis_tvalid, unused_bytes == '0, "byte of absent pad set")

endmodule

bind gamepad_event_to_pad_bits gpb_checker #(.NUM_PADS(NUM_PADS)) u_gpb_checker (.*);

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for gamepad_event_to_pad_bits: joystick events and polls are
// streamed in, and each poll word is compared against an in-bench pad state predictor.
// Depends on gpb_pkg and the gamepad_event_to_pad_bits RTL.
module tb;
  import gpb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_MAP_PAD3 + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = {CFG_IDX_W{1'b1}};

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [MAP_W-1:0]     cfg_data_i = '0;

  gamepad_event_to_pad_bits u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [3:0]         pad_on;
  logic [MAP_W-1:0]   button_map [MAX_PADS];
  logic [31:0]        held_buttons [MAX_PADS];
  logic signed [15:0] stick_x [MAX_PADS];
  logic signed [15:0] stick_y [MAX_PADS];
  logic               turbo_odd;

  gpb_req_t          pending_reqs [$];
  logic [31:0]       want_words [$];
  gpb_req_t          on_bus;
  int                n_errors = 0;
  int                cycles = 0;
  int                s_hold = 0;
  int                m_hold = 0;
  logic              s_idle_on = 1'b1;
  logic              m_idle_on = 1'b1;

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic void apply_joy_event(gpb_req_t r);
    logic [6:0] kind;
    kind = r.ev_type[6:0];
    if (int'(r.pad) >= MAX_PADS || !pad_on[r.pad]) return;
    if (kind == EVT_BUTTON) begin
      if (r.number < 8'd32) held_buttons[r.pad][r.number[4:0]] = (r.value != 16'sd0);
    end else if (kind == EVT_AXIS) begin
      if (r.number == AXIS_X) stick_x[r.pad] = r.value;
      else if (r.number == AXIS_Y) stick_y[r.pad] = r.value;
    end
  endfunction

  function automatic logic [7:0] pad_byte(int p);
    logic [7:0] b;
    logic [5:0] ent;
    b = '0;
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      ent = button_map[p][ENTRY_W*e +: ENTRY_W];
      if (ent[5] && held_buttons[p][ent[4:0]] && (e < 4 || turbo_odd)) b[e % 4] = 1'b1;
    end
    if (stick_x[p] <= -AXIS_LIMIT) b[BIT_LEFT] = 1'b1;
    else if (stick_x[p] >= AXIS_LIMIT) b[BIT_RIGHT] = 1'b1;
    if (stick_y[p] <= -AXIS_LIMIT) b[BIT_UP] = 1'b1;
    else if (stick_y[p] >= AXIS_LIMIT) b[BIT_DOWN] = 1'b1;
    return b;
  endfunction

  function automatic logic [31:0] poll_pad_word();
    logic [31:0] w;
    w = '0;
    turbo_odd = ~turbo_odd;
    for (int p = 0; p < MAX_PADS; p++) begin
      if (pad_on[p]) w[8*p +: 8] = pad_byte(p);
    end
    return w;
  endfunction

  function automatic gpb_req_t mk(gpb_req_e req, int pad, int kind, int num, int val);
    gpb_req_t r;
    r.req     = req;
    r.pad     = 2'(pad);
    r.ev_type = 8'(kind);
    r.number  = 8'(num);
    r.value   = 16'(val);
    return r;
  endfunction

  function automatic logic signed [15:0] pick_stick_value();
    case ($urandom_range(0, 9))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return -AXIS_LIMIT;
      3: return AXIS_LIMIT;
      4: return -AXIS_LIMIT + 16'sd1;
      5: return AXIS_LIMIT - 16'sd1;
      6: return 16'sd0;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic gpb_req_t rand_request();
    gpb_req_t r;
    int sel;
    int k;
    r = mk(REQ_EVENT, $urandom_range(0, 3), $urandom, $urandom, $urandom);
    sel = $urandom_range(0, 99);
    k = $urandom_range(0, NUM_ENTRIES - 1);
    if (sel < 25) begin
      r.req = REQ_POLL;
    end else if (sel < 65) begin
      r.ev_type = $urandom_range(0, 3) == 0 ? {1'b1, EVT_BUTTON} : {1'b0, EVT_BUTTON};
      if ($urandom_range(0, 9) < 6) r.number = {3'b000, button_map[r.pad][ENTRY_W*k +: 5]};
      else if ($urandom_range(0, 4) != 0) r.number = 8'($urandom_range(0, 31));
      if ($urandom_range(0, 2) == 0) r.value = 16'sd0;
      else if ($urandom_range(0, 1) == 0) r.value = 16'sd1;
    end else if (sel < 90) begin
      r.ev_type = $urandom_range(0, 3) == 0 ? {1'b1, EVT_AXIS} : {1'b0, EVT_AXIS};
      if ($urandom_range(0, 7) != 0) r.number = 8'($urandom_range(0, 1));
      r.value = pick_stick_value();
    end
    return r;
  endfunction

  function automatic logic [MAP_W-1:0] rand_map();
    logic [MAP_W-1:0] m;
    case ($urandom_range(0, 9))
      0: m = '0;
      1: m = '1;
      default: begin
        for (int e = 0; e < NUM_ENTRIES; e++) begin
          m[ENTRY_W*e +: ENTRY_W] = {$urandom_range(0, 9) != 0, 5'($urandom)};
        end
      end
    endcase
    return m;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MAP_W-1:0] data);
    @(posedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_PAD_ENABLE: pad_on = data[3:0];
      CFG_MAP_PAD0:   button_map[0] = data;
      CFG_MAP_PAD1:   button_map[1] = data;
      CFG_MAP_PAD2:   button_map[2] = data;
      CFG_MAP_PAD3:   button_map[3] = data;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic program_regs(logic [3:0] en, logic [MAP_W-1:0] map0);
    write_reg(CFG_PAD_ENABLE, {{(MAP_W-4){1'b1}}, en});
    write_reg(CFG_MAP_PAD0, map0);
    write_reg(CFG_MAP_PAD1, rand_map());
    write_reg(CFG_MAP_PAD2, rand_map());
    write_reg(CFG_MAP_PAD3, rand_map());
    write_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)), {MAP_W{1'b1}});
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || s_axis_tvalid || want_words.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (on_bus.req == REQ_POLL) want_words.push_back(poll_pad_word());
        else apply_joy_event(on_bus);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (s_hold > 0) begin
          s_hold--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          on_bus = pending_reqs.pop_front();
          s_axis_tdata  <= {6'b0, on_bus.value, on_bus.number, on_bus.ev_type, on_bus.pad};
          s_axis_tuser  <= on_bus.req;
          s_axis_tvalid <= 1'b1;
          s_hold = s_idle_on ? draw_gap() : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    logic [31:0] want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (want_words.size() == 0) begin
          $error("pad_bits: unexpected transaction, actual %08h", m_axis_tdata);
          n_errors++;
        end else begin
          want = want_words.pop_front();
          if (m_axis_tdata !== want) begin
            $error("pad_bits mismatch: expected %08h, actual %08h", want, m_axis_tdata);
            n_errors++;
          end
        end
      end
      if (m_hold > 0) begin
        m_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (m_idle_on) m_hold = draw_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    logic [3:0] en;
    pad_on = '0;
    turbo_odd = 1'b0;
    for (int p = 0; p < MAX_PADS; p++) begin
      button_map[p] = '0;
      held_buttons[p] = '0;
      stick_x[p] = '0;
      stick_y[p] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    program_regs(4'hF, {1'b1, 5'd8, 1'b1, 5'd7, 1'b1, 5'd6, 1'b1, 5'd5, 1'b1, 5'd31,
                        1'b1, 5'd0});
    pending_reqs.push_back(mk(REQ_POLL, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_EVENT, 0, EVT_BUTTON, 0, 1));
    pending_reqs.push_back(mk(REQ_EVENT, 0, {1'b1, EVT_BUTTON}, 31, -32768));
    pending_reqs.push_back(mk(REQ_EVENT, 0, EVT_BUTTON, 32, 1));
    pending_reqs.push_back(mk(REQ_EVENT, 0, EVT_BUTTON, 255, 1));
    pending_reqs.push_back(mk(REQ_EVENT, 0, EVT_BUTTON, 7, 1));
    pending_reqs.push_back(mk(REQ_POLL, 3, 255, 255, -1));
    pending_reqs.push_back(mk(REQ_POLL, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_EVENT, 0, EVT_AXIS, AXIS_X, -16383));
    pending_reqs.push_back(mk(REQ_EVENT, 0, {1'b1, EVT_AXIS}, AXIS_Y, 16383));
    pending_reqs.push_back(mk(REQ_EVENT, 1, EVT_AXIS, AXIS_X, 16382));
    pending_reqs.push_back(mk(REQ_EVENT, 1, EVT_AXIS, AXIS_Y, -16382));
    pending_reqs.push_back(mk(REQ_EVENT, 2, EVT_AXIS, AXIS_X, 32767));
    pending_reqs.push_back(mk(REQ_EVENT, 2, EVT_AXIS, AXIS_Y, -32768));
    pending_reqs.push_back(mk(REQ_EVENT, 0, EVT_AXIS, 2, 32767));
    pending_reqs.push_back(mk(REQ_EVENT, 0, 0, 5, 1));
    pending_reqs.push_back(mk(REQ_EVENT, 0, 255, 6, 1));
    pending_reqs.push_back(mk(REQ_EVENT, 0, 3, 8, 1));
    pending_reqs.push_back(mk(REQ_POLL, 1, 1, 1, 1));
    pending_reqs.push_back(mk(REQ_EVENT, 0, EVT_BUTTON, 0, 0));
    pending_reqs.push_back(mk(REQ_EVENT, 3, EVT_AXIS, 255, 16'h5555));
    pending_reqs.push_back(mk(REQ_POLL, 2, 2, 0, 16'haaaa));

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      s_idle_on = $urandom_range(0, 3) != 0;
      m_idle_on = $urandom_range(0, 3) != 0;
      case (ph)
        0: en = 4'h0;
        1: en = 4'hF;
        default: en = 4'($urandom);
      endcase
      program_regs(en, rand_map());
      for (int i = 0; i < 50; i++) pending_reqs.push_back(rand_request());
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/gpb_pkg.sv
rtl/gpb_pad_state.sv
rtl/gpb_poll.sv
rtl/gamepad_event_to_pad_bits.sv
rtl/gpb_checker.sv
dv/tb.sv
